@@ rtl/skht_pkg.sv @@
// ----------------------------------------------------------------------------
// skht_pkg
// Types, sizes and codes shared by the string-keyed hash table.
// ----------------------------------------------------------------------------
package skht_pkg;

    // The slot count is a power of two so the hash reduces to its low bits.
    localparam int SLOT_W      = 9;
    localparam int TABLE_SLOTS = 1 << SLOT_W;
    localparam int STORE_BYTES = 8192;
    localparam int STORE_W     = $clog2(STORE_BYTES);
    localparam int KEY_MAX     = 128;
    localparam int LEN_W       = $clog2(KEY_MAX + 1);
    localparam int KB_W        = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_ILLEGAL  = 3'd1;
    localparam logic [2:0] ST_TFULL    = 3'd2;
    localparam logic [2:0] ST_SFULL    = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  key_byte;
        logic [31:0] entry_date;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_date;
    } t_out;

endpackage

@@ rtl/string_key_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// string_key_hash_table_top
// Symbol table of byte-string keys holding a 32-bit date per key.
//
// Usage: an item is transferred when i_start is high and o_busy is low. Each
// item carries a mode, one key byte and a date. A nonzero byte is appended
// to the key and gives no result. A zero byte runs the insert
// or lookup; clear mode acts on any item. Each result is shown on o_out for
// one cycle with o_done high; the receiver cannot stall.
// Operation: a key byte leaves the block idle. A terminator probes slots
// linearly: each slot is read (S_SLOT_RD, S_SLOT_CK), each occupied slot is
// compared byte by byte (S_CMP_RD, S_CMP_CK) over key length plus one bytes
// until a mismatch, and a new key is copied byte by byte into the string
// store (S_CPY_RD, S_CPY_WR); store and key buffer each have one read port.
// Empty-key and zero-date cases answer in the cycle after transfer.
// Reset and clear: the slot table is swept to empty, one slot a cycle, over
// all TABLE_SLOTS (512) slots while o_busy is high; the clear result
// is given at the start of the sweep.
// ----------------------------------------------------------------------------
module string_key_hash_table_top
    import skht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    output logic o_busy,
    output logic o_done,
    output t_out o_out
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_SLOT_RD = 4'd2;
    localparam logic [3:0] S_SLOT_CK = 4'd3;
    localparam logic [3:0] S_CMP_RD  = 4'd4;
    localparam logic [3:0] S_CMP_CK  = 4'd5;
    localparam logic [3:0] S_CPY_RD  = 4'd6;
    localparam logic [3:0] S_CPY_WR  = 4'd7;

    logic [3:0]         r_state;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_cnt;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_j;
    logic [SLOT_W-1:0]  r_hash;
    logic [STORE_W-1:0] r_fill;
    logic               r_lookup;
    logic [31:0]        r_date;
    logic               r_done;
    t_out               r_out;

    logic [STORE_W-1:0] mem_off  [TABLE_SLOTS];
    logic [31:0]        mem_date [TABLE_SLOTS];
    logic [7:0]         mem_str  [STORE_BYTES];
    logic [7:0]         mem_key  [KEY_MAX];

    logic [STORE_W-1:0] rd_off;
    logic [31:0]        rd_date;
    logic [7:0]         rd_str;
    logic [7:0]         rd_key;

    logic               accept;
    logic [STORE_W:0]   cmp_addr;
    logic [STORE_W:0]   cpy_addr;
    logic [STORE_W:0]   fill_need;
    logic               off_we;
    logic [SLOT_W-1:0]  off_wa;
    logic [STORE_W-1:0] off_wd;
    logic               date_we;
    logic               str_we;
    logic [STORE_W-1:0] str_ra;
    logic               key_we;
    logic               last_byte;
    logic               byte_ok;

    assign accept    = i_start && (r_state == S_IDLE);
    assign cmp_addr  = {1'b0, rd_off} + (STORE_W+1)'(r_j);
    assign cpy_addr  = {1'b0, r_fill} + (STORE_W+1)'(r_j);
    assign fill_need = {1'b0, r_fill} + (STORE_W+1)'(r_len) + (STORE_W+1)'(1);
    assign last_byte = (r_j == r_len);
    assign str_ra    = cmp_addr[STORE_W-1:0];
    assign key_we    = accept && (i_in.mode != MODE_CLEAR) && (i_in.key_byte != 8'd0)
                       && (r_len < LEN_W'(KEY_MAX));
    assign str_we    = (r_state == S_CPY_WR);
    assign date_we   = ((r_state == S_CMP_CK) && byte_ok && last_byte && !r_lookup)
                       || ((r_state == S_CPY_WR) && last_byte);

    always_comb begin
        if (cmp_addr >= (STORE_W+1)'(STORE_BYTES)) begin
            byte_ok = 1'b0;
        end else if (last_byte) begin
            byte_ok = (rd_str == 8'd0);
        end else begin
            byte_ok = (rd_str == rd_key);
        end
    end

    always_comb begin
        off_we = 1'b0;
        off_wa = r_slot;
        off_wd = r_fill;
        if (r_state == S_CLR) begin
            off_we = 1'b1;
            off_wd = '0;
        end else if ((r_state == S_CPY_WR) && last_byte) begin
            off_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            mem_off[off_wa] <= off_wd;
        end
        rd_off <= mem_off[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (date_we) begin
            mem_date[r_slot] <= r_date;
        end
        rd_date <= mem_date[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (str_we) begin
            mem_str[cpy_addr[STORE_W-1:0]] <= last_byte ? 8'd0 : rd_key;
        end
        rd_str <= mem_str[str_ra];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[r_len[KB_W-1:0]] <= i_in.key_byte;
        end
        rd_key <= mem_key[r_j[KB_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_slot   <= '0;
            r_len    <= '0;
            r_hash   <= '0;
            r_fill   <= STORE_W'(1);
            r_done   <= 1'b0;
            r_j      <= '0;
            r_cnt    <= '0;
            r_lookup <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_date   <= i_in.entry_date;
                        r_lookup <= (i_in.mode != MODE_INSERT);
                        r_out.found_date <= '0;
                        if (i_in.mode == MODE_CLEAR) begin
                            r_len  <= '0;
                            r_hash <= '0;
                            r_fill <= STORE_W'(1);
                            r_slot <= '0;
                            r_done <= 1'b1;
                            r_out.status <= ST_CLEARED;
                            r_state <= S_CLR;
                        end else if (i_in.key_byte != 8'd0) begin
                            if (key_we) begin
                                r_len  <= r_len + LEN_W'(1);
                                r_hash <= {r_hash[SLOT_W-2:0], 1'b0}
                                          + SLOT_W'(i_in.key_byte);
                            end
                        end else begin
                            r_hash <= '0;
                            if (i_in.mode == MODE_INSERT
                                && (r_len == '0 || i_in.entry_date == 32'd0)) begin
                                r_done <= 1'b1;
                                r_out.status <= ST_ILLEGAL;
                                r_len <= '0;
                            end else if (r_len == '0) begin
                                r_done <= 1'b1;
                                r_out.status <= ST_NOTFOUND;
                            end else begin
                                r_slot  <= r_hash;
                                r_cnt   <= '0;
                                r_state <= S_SLOT_RD;
                            end
                        end
                    end
                end
                S_CLR: begin
                    r_slot <= r_slot + SLOT_W'(1);
                    if (r_slot == SLOT_W'(TABLE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SLOT_RD: begin
                    r_state <= S_SLOT_CK;
                end
                S_SLOT_CK: begin
                    r_j <= '0;
                    if (rd_off != '0) begin
                        r_state <= S_CMP_RD;
                    end else if (r_lookup) begin
                        r_done <= 1'b1;
                        r_out.status <= ST_NOTFOUND;
                        r_len <= '0;
                        r_state <= S_IDLE;
                    end else if (fill_need >= (STORE_W+1)'(STORE_BYTES)) begin
                        r_done <= 1'b1;
                        r_out.status <= ST_SFULL;
                        r_len <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CPY_RD;
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_CMP_CK;
                end
                S_CMP_CK: begin
                    if (!byte_ok) begin
                        if (r_cnt == SLOT_W'(TABLE_SLOTS - 1)) begin
                            r_done <= 1'b1;
                            r_out.status <= r_lookup ? ST_NOTFOUND : ST_TFULL;
                            r_len <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot + SLOT_W'(1);
                            r_cnt   <= r_cnt + SLOT_W'(1);
                            r_state <= S_SLOT_RD;
                        end
                    end else if (last_byte) begin
                        r_done <= 1'b1;
                        r_len  <= '0;
                        r_state <= S_IDLE;
                        if (r_lookup) begin
                            r_out.status     <= ST_FOUND;
                            r_out.found_date <= rd_date;
                        end else begin
                            r_out.status <= ST_STORED;
                        end
                    end else begin
                        r_j     <= r_j + LEN_W'(1);
                        r_state <= S_CMP_RD;
                    end
                end
                S_CPY_RD: begin
                    r_state <= S_CPY_WR;
                end
                S_CPY_WR: begin
                    if (last_byte) begin
                        r_fill <= fill_need[STORE_W-1:0];
                        r_done <= 1'b1;
                        r_out.status <= ST_STORED;
                        r_len <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + LEN_W'(1);
                        r_state <= S_CPY_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

    // A clear answers in the very next cycle.
    a_clear_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.mode == MODE_CLEAR |=> o_done && o_out.status == ST_CLEARED)
        else $error("clear did not answer");

    // A date is reported only with a found status.
    a_date_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.status != ST_FOUND |-> o_out.found_date == 32'd0)
        else $error("date given without a hit");

    // Offset zero marks an empty slot, so the store fill never returns to it.
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != '0)
        else $error("store fill reached zero");

    // New keys are only copied while the store has room for them.
    a_copy_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        str_we |-> fill_need < (STORE_W+1)'(STORE_BYTES))
        else $error("string store overrun");

endmodule

@@ sim/string_key_hash_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// string_key_hash_table_top_tb
// Self-checking bench for the string-keyed hash table. A scoreboard keeps its
// own copy of the slots, the string store and the partial key, predicts the
// result of every terminator or clear, and compares each strobed result with
// the oldest prediction. Directed keys and a long random mix with idle
// bursts are driven.
// ----------------------------------------------------------------------------
module string_key_hash_table_top_tb;
    import skht_pkg::*;

    class skht_scoreboard;
        int unsigned slot_off [TABLE_SLOTS];
        logic [31:0] slot_dt  [TABLE_SLOTS];
        logic [7:0]  store    [STORE_BYTES];
        logic [7:0]  kbuf     [KEY_MAX];
        int unsigned fill;
        int unsigned klen;
        logic [31:0] hash;
        t_out        pending [$];
        int          errors;
        int          n_results;

        function new();
            errors = 0;
            n_results = 0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (slot_off[i]) slot_off[i] = 0;
            fill = 1;
            klen = 0;
            hash = '0;
        endfunction

        function bit key_at(int unsigned off);
            for (int unsigned j = 0; j < klen; j++) begin
                if (off + j >= STORE_BYTES || store[off + j] != kbuf[j]) return 0;
            end
            if (off + klen >= STORE_BYTES) return 0;
            return store[off + klen] == 8'd0;
        endfunction

        // Returns 1 when the key is present; slot then holds it. Otherwise
        // slot is the first empty slot when has_empty says that one exists.
        function bit find_slot(output int unsigned slot, output bit has_empty);
            int unsigned idx;
            idx = hash % TABLE_SLOTS;
            has_empty = 0;
            slot = idx;
            for (int n = 0; n < TABLE_SLOTS; n++) begin
                if (slot_off[idx] == 0) begin
                    slot = idx;
                    has_empty = 1;
                    return 0;
                end
                if (key_at(slot_off[idx])) begin
                    slot = idx;
                    return 1;
                end
                idx = (idx + 1) % TABLE_SLOTS;
            end
            return 0;
        endfunction

        function void note(t_in it);
            t_out        res;
            int unsigned slot;
            bit          has_empty;
            res.status = ST_STORED;
            res.found_date = '0;
            if (it.mode == MODE_CLEAR) begin
                clear_all();
                res.status = ST_CLEARED;
                pending.push_back(res);
                return;
            end
            if (it.key_byte != 8'd0) begin
                if (klen < KEY_MAX) begin
                    kbuf[klen] = it.key_byte;
                    klen++;
                    hash = hash + hash + it.key_byte;
                end
                return;
            end
            if (it.mode == MODE_INSERT) begin
                if (klen == 0 || it.entry_date == 0) begin
                    res.status = ST_ILLEGAL;
                end else if (find_slot(slot, has_empty)) begin
                    slot_dt[slot] = it.entry_date;
                end else if (!has_empty) begin
                    res.status = ST_TFULL;
                end else if (fill + klen + 1 >= STORE_BYTES) begin
                    res.status = ST_SFULL;
                end else begin
                    for (int unsigned j = 0; j < klen; j++) store[fill + j] = kbuf[j];
                    store[fill + klen] = 8'd0;
                    slot_off[slot] = fill;
                    slot_dt[slot] = it.entry_date;
                    fill += klen + 1;
                end
            end else begin
                // Lookup, and the undefined mode which behaves as one.
                if (klen != 0 && find_slot(slot, has_empty)) begin
                    res.status = ST_FOUND;
                    res.found_date = slot_dt[slot];
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            klen = 0;
            hash = '0;
            pending.push_back(res);
        endfunction

        function void check(t_out got);
            t_out want;
            n_results++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d date=%h", $time,
                         got.status, got.found_date);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, got.status);
                errors++;
            end
            if (got.found_date !== want.found_date) begin
                $display("%0t: found_date expected %h actual %h", $time,
                         want.found_date, got.found_date);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCH_LIMIT = 400000;
    localparam int N_ITEMS     = 1350;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_in;
    logic o_busy;
    logic o_done;
    t_out o_out;

    skht_scoreboard sb;
    bit      quiet_phase;
    int      idle_count;
    int      n_items;
    int      n_clears;

    string_key_hash_table_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check(o_out);
        if (i_rst_n && ((i_start && !o_busy) || o_done)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count > WATCH_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("string_key_hash_table_top_tb failed");
            $finish;
        end
    end

    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 10);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // One item transfer; the caller is at a falling edge or just after reset.
    task automatic send_item(logic [1:0] mode, logic [7:0] kb, logic [31:0] dt);
        t_in it;
        if (!quiet_phase && $urandom_range(0, 11) == 0) idle_burst();
        it.mode = mode;
        it.key_byte = kb;
        it.entry_date = dt;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_in <= it;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        sb.note(it);
        n_items++;
        if (mode == MODE_CLEAR) n_clears++;
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic send_key(logic [1:0] mode, logic [7:0] key [$], logic [31:0] dt);
        foreach (key[i]) send_item(mode, key[i], $urandom);
        send_item(mode, 8'd0, dt);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    logic [7:0] key_pool [40][$];

    initial begin
        logic [7:0] k [$];
        logic [7:0] ka [$];
        int r;
        int p;
        sb = new();
        quiet_phase = 0;
        idle_count = 0;
        n_items = 0;
        n_clears = 0;
        i_start = 1'b0;
        i_in = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: update, prefix keys, illegal cases, long key, odd mode.
        k = '{8'h41};
        send_key(MODE_INSERT, k, 32'd1);
        send_key(MODE_LOOKUP, k, 32'd0);
        send_key(MODE_INSERT, k, 32'hFFFFFFFF);
        send_key(MODE_LOOKUP, k, 32'd0);
        ka = '{8'h41, 8'hFF};
        send_key(MODE_LOOKUP, ka, 32'd0);
        send_key(MODE_INSERT, ka, 32'h80000000);
        send_key(2'd3, ka, 32'd0);
        send_key(MODE_INSERT, k, 32'd0);
        send_item(MODE_INSERT, 8'd0, 32'd5);
        send_item(MODE_LOOKUP, 8'd0, 32'd0);
        send_item(MODE_INSERT, 8'h80, 32'd0);
        send_item(MODE_CLEAR, 8'h7F, 32'd0);
        send_key(MODE_LOOKUP, k, 32'd0);
        k = {};
        for (int i = 0; i < KEY_MAX + 3; i++) k.push_back(8'($urandom_range(1, 255)));
        send_key(MODE_INSERT, k, 32'h12345678);
        k = k[0:KEY_MAX-1];
        send_key(MODE_LOOKUP, k, 32'd0);
        drain();
        send_item(MODE_CLEAR, 8'd0, 32'd0);

        // Random mix over a small pool of short keys so lookups often hit.
        foreach (key_pool[i]) begin
            p = $urandom_range(1, 8);
            for (int j = 0; j < p; j++) key_pool[i].push_back(8'($urandom_range(1, 255)));
        end
        while (n_items < N_ITEMS) begin
            if (n_items > N_ITEMS - 200) quiet_phase = 1;
            r = $urandom_range(0, 99);
            p = $urandom_range(0, 39);
            if (r < 50) begin
                send_key(MODE_INSERT, key_pool[p], $urandom);
            end else if (r < 85) begin
                send_key(MODE_LOOKUP, key_pool[p], 32'd0);
            end else if (r < 88) begin
                send_item(MODE_CLEAR, 8'($urandom), $urandom);
            end else if (r < 92) begin
                send_key(2'd3, key_pool[p], $urandom);
            end else if (r < 96) begin
                // A key cut short by a clear before its terminator.
                k = key_pool[p];
                foreach (k[i]) send_item(MODE_INSERT, k[i], $urandom);
                send_item(MODE_CLEAR, 8'($urandom), $urandom);
            end else begin
                send_item(2'($urandom_range(0, 3) & 2'd1), 8'd0, $urandom);
            end
            if (n_items > 700 && n_items < 750) drain();
        end

        drain();
        repeat (TABLE_SLOTS + 100) @(negedge i_clk);
        $display("Exercised inserts, updates, lookups, clears, illegal keys and dates,");
        $display("over-long keys and cut keys: %0d items, %0d results, %0d clears.",
                 n_items, sb.n_results, n_clears);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("string_key_hash_table_top_tb passed");
        end else begin
            $display("string_key_hash_table_top_tb failed");
        end
        $finish;
    end

endmodule
